// ===== rtl/core/grc_pkg.sv =====
// ----------------------------------------------------------------------------
// grc_pkg
// Shared widths, constants and types of the gas ratio to concentration block.
// ----------------------------------------------------------------------------
package grc_pkg;

  // fraction bits of the sensing ratios
  localparam int RATIO_FRAC_BITS = 16;

  localparam int RAW_W = 16;
  // full ratio quotient, one bit per divider step
  localparam int RQ_W = RAW_W + RATIO_FRAC_BITS;
  // reducing ratio clamped to [0, 1.0]
  localparam int RC_W = RATIO_FRAC_BITS + 1;
  // oxidising ratio clamped to [0, 64.0]
  localparam int OC_W = RATIO_FRAC_BITS + 7;
  localparam int PROD_W = RATIO_FRAC_BITS + 21;
  localparam int CMP_W = RATIO_FRAC_BITS + 11;

  // lane operand and lane divider widths
  localparam int Y_W = 20;
  localparam int DIV_W = 10;
  localparam int LQ_W = 16;
  localparam int VAL_W = 15;
  localparam int NLANE = 6;

  localparam int RDIV_STEPS = RQ_W;
  localparam int CDIV_STEPS = LQ_W;
  localparam int CNT_W = $clog2(RDIV_STEPS);

  // lanes
  localparam int LN_CO = 0;
  localparam int LN_CH4 = 1;
  localparam int LN_ETH = 2;
  localparam int LN_H2 = 3;
  localparam int LN_NH3 = 4;
  localparam int LN_NO2 = 5;

  localparam logic [DIV_W-1:0] LANE_DIV [NLANE] =
    '{10'd405, 10'd23, 10'd57, 10'd26, 10'd15, 10'd613};
  localparam logic [VAL_W-1:0] LANE_LOW [NLANE] =
    '{15'd1, 15'd1000, 15'd10, 15'd1, 15'd1, 15'd10};
  localparam logic [VAL_W-1:0] LANE_HIGH [NLANE] =
    '{15'd1000, 15'd25000, 15'd500, 15'd1000, 15'd500, 15'd1000};

  // curve offsets: threshold times output scale
  localparam logic [Y_W-1:0] K_CO = 20'd425000;
  localparam logic [Y_W-1:0] K_CH4 = 20'd786000;
  localparam logic [Y_W-1:0] K_ETH = 20'd30600;
  localparam logic [Y_W-1:0] K_H2 = 20'd27900;
  localparam logic [Y_W-1:0] K_NH3 = 20'd8000;
  localparam logic [Y_W:0] NO2_OFS = 21'd450;

  localparam logic [Y_W-1:0] MUL_E6 = 20'd1000000;
  localparam logic [Y_W-1:0] MUL_E5 = 20'd100000;
  localparam logic [Y_W-1:0] MUL_E4 = 20'd10000;

  localparam logic [PROD_W-1:0] ROUND_UP =
    {{(PROD_W-RATIO_FRAC_BITS){1'b0}}, {RATIO_FRAC_BITS{1'b1}}};

  localparam logic [RQ_W-1:0] RED_CAP_Q = RQ_W'(1) << RATIO_FRAC_BITS;
  localparam logic [RQ_W-1:0] OX_CAP_Q = RQ_W'(64) << RATIO_FRAC_BITS;

  localparam logic [CMP_W-1:0] TH_PROPANE = CMP_W'(18) << RATIO_FRAC_BITS;
  localparam logic [CMP_W-1:0] TH_ISOBUT = CMP_W'(65) << RATIO_FRAC_BITS;
  localparam logic [CMP_W-1:0] TH_H2S_LO = CMP_W'(58) << RATIO_FRAC_BITS;
  localparam logic [CMP_W-1:0] TH_H2S_HI = CMP_W'(69) << RATIO_FRAC_BITS;
  localparam logic [CMP_W-1:0] TH_H2S_LOW = CMP_W'(201) << RATIO_FRAC_BITS;
  localparam logic [CMP_W-1:0] TH_NO = CMP_W'(8) << RATIO_FRAC_BITS;
  localparam logic [CMP_W-1:0] TH_NO2_ON = CMP_W'(11) << RATIO_FRAC_BITS;

  // item kinds
  localparam logic KIND_CAL = 1'b0;
  localparam logic KIND_MEAS = 1'b1;

  // field widths and detection flag positions
  localparam int IN_DATA_W = 48;
  localparam int CO_W = 10;
  localparam int CH4_W = 15;
  localparam int ETH_W = 9;
  localparam int H2_W = 10;
  localparam int NH3_W = 9;
  localparam int NO2_W = 10;
  localparam int FLAGS_W = 10;
  localparam int OUT_DATA_W = 80;
  localparam int OUT_PAD_W =
    OUT_DATA_W - (CO_W + CH4_W + ETH_W + H2_W + NH3_W + NO2_W + FLAGS_W);

  localparam int FL_CO = 0;
  localparam int FL_CH4 = 1;
  localparam int FL_ETH = 2;
  localparam int FL_PROPANE = 3;
  localparam int FL_ISOBUT = 4;
  localparam int FL_H2 = 5;
  localparam int FL_H2S = 6;
  localparam int FL_NH3 = 7;
  localparam int FL_NO = 8;
  localparam int FL_NO2 = 9;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDIV,
    ST_CLAMP,
    ST_SCALE,
    ST_CDIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic           neg;
    logic [Y_W-1:0] mag;
  } lane_op_t;

  typedef struct packed {
    lane_op_t [NLANE-1:0] lane;
    logic                 propane;
    logic                 isobutane;
    logic                 h2s;
    logic                 nitric;
  } scale_t;

endpackage

// ===== rtl/core/grc_rdiv.sv =====
// ----------------------------------------------------------------------------
// grc_rdiv
// Bit-serial restoring divider: (mag * 2^F) / divisor, one quotient bit a cycle while en is high.
// ----------------------------------------------------------------------------
module grc_rdiv (
  input  logic                        clk,
  input  logic                        load,
  input  logic                        en,
  input  logic [grc_pkg::RAW_W-1:0]   mag,
  input  logic [grc_pkg::RAW_W-1:0]   divisor,
  output logic [grc_pkg::RQ_W-1:0]    quo
);

  logic [grc_pkg::RQ_W-1:0]  dvd_r, dvd_nxt;
  logic [grc_pkg::RAW_W-1:0] rem_r, rem_nxt;
  logic [grc_pkg::RAW_W:0]   trial;
  logic [grc_pkg::RAW_W:0]   diff;
  logic                      ge;

  always_comb begin
    trial = {rem_r, dvd_r[grc_pkg::RQ_W-1]};
    diff = trial - {1'b0, divisor};
    ge = (trial >= {1'b0, divisor});
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    if (load) begin
      dvd_nxt = {mag, {grc_pkg::RATIO_FRAC_BITS{1'b0}}};
      rem_nxt = '0;
    end else if (en) begin
      // dividend bits leave at the top, quotient bits enter at the bottom
      dvd_nxt = {dvd_r[grc_pkg::RQ_W-2:0], ge};
      rem_nxt = ge ? diff[grc_pkg::RAW_W-1:0] : trial[grc_pkg::RAW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign quo = dvd_r;

endmodule

// ===== rtl/core/grc_scale.sv =====
// ----------------------------------------------------------------------------
// grc_scale
// Clamps the two ratios and forms the lane operands and the ratio flags.
// ----------------------------------------------------------------------------
module grc_scale (
  input  logic                      clk,
  input  logic                      clamp_en,
  input  logic [grc_pkg::RQ_W-1:0]  red_q,
  input  logic                      red_neg,
  input  logic [grc_pkg::RQ_W-1:0]  ox_q,
  input  logic                      ox_neg,
  output grc_pkg::scale_t           res
);

  logic [grc_pkg::RC_W-1:0]   rc_r, rc_nxt;
  logic [grc_pkg::OC_W-1:0]   oc_r, oc_nxt;
  logic [grc_pkg::PROD_W-1:0] p6, p5, p4, pn;
  logic [grc_pkg::PROD_W-1:0] s6, s5, s4;
  logic [grc_pkg::Y_W:0]      c6, c5, c4, fn;
  logic [grc_pkg::Y_W:0]      y_co, y_ch4, y_eth, y_h2, y_nh3, y_no2;
  logic [grc_pkg::CMP_W-1:0]  r10, r100, r1000, o10;
  logic                       no2_on;

  // negative ratios act as zero, large ones as the cap: results are unchanged
  always_comb begin
    rc_nxt = rc_r;
    oc_nxt = oc_r;
    if (clamp_en) begin
      if (red_neg) begin
        rc_nxt = '0;
      end else if (red_q > grc_pkg::RED_CAP_Q) begin
        rc_nxt = grc_pkg::RED_CAP_Q[grc_pkg::RC_W-1:0];
      end else begin
        rc_nxt = red_q[grc_pkg::RC_W-1:0];
      end
      if (ox_neg) begin
        oc_nxt = '0;
      end else if (ox_q > grc_pkg::OX_CAP_Q) begin
        oc_nxt = grc_pkg::OX_CAP_Q[grc_pkg::OC_W-1:0];
      end else begin
        oc_nxt = ox_q[grc_pkg::OC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    rc_r <= rc_nxt;
    oc_r <= oc_nxt;
  end

  always_comb begin
    p6 = grc_pkg::PROD_W'(rc_r) * grc_pkg::PROD_W'(grc_pkg::MUL_E6);
    p5 = grc_pkg::PROD_W'(rc_r) * grc_pkg::PROD_W'(grc_pkg::MUL_E5);
    p4 = grc_pkg::PROD_W'(rc_r) * grc_pkg::PROD_W'(grc_pkg::MUL_E4);
    pn = grc_pkg::PROD_W'(oc_r) * grc_pkg::PROD_W'(grc_pkg::MUL_E4);
    // ceiling of product / 2^F for c6, c5 and c4; fn takes the floor
    s6 = p6 + grc_pkg::ROUND_UP;
    s5 = p5 + grc_pkg::ROUND_UP;
    s4 = p4 + grc_pkg::ROUND_UP;
    c6 = s6[grc_pkg::PROD_W-1:grc_pkg::RATIO_FRAC_BITS];
    c5 = s5[grc_pkg::PROD_W-1:grc_pkg::RATIO_FRAC_BITS];
    c4 = s4[grc_pkg::PROD_W-1:grc_pkg::RATIO_FRAC_BITS];
    fn = pn[grc_pkg::PROD_W-1:grc_pkg::RATIO_FRAC_BITS];

    y_co = {1'b0, grc_pkg::K_CO} - c6;
    y_ch4 = {1'b0, grc_pkg::K_CH4} - c6;
    y_eth = {1'b0, grc_pkg::K_ETH} - c5;
    y_h2 = {1'b0, grc_pkg::K_H2} - c5;
    y_nh3 = {1'b0, grc_pkg::K_NH3} - c4;

    o10 = grc_pkg::CMP_W'(oc_r) * grc_pkg::CMP_W'(10);
    no2_on = (o10 >= grc_pkg::TH_NO2_ON);
    y_no2 = no2_on ? (fn - grc_pkg::NO2_OFS) : {1'b1, {grc_pkg::Y_W{1'b0}}};

    res.lane[grc_pkg::LN_CO] = {y_co[grc_pkg::Y_W], y_co[grc_pkg::Y_W-1:0]};
    res.lane[grc_pkg::LN_CH4] = {y_ch4[grc_pkg::Y_W], y_ch4[grc_pkg::Y_W-1:0]};
    res.lane[grc_pkg::LN_ETH] = {y_eth[grc_pkg::Y_W], y_eth[grc_pkg::Y_W-1:0]};
    res.lane[grc_pkg::LN_H2] = {y_h2[grc_pkg::Y_W], y_h2[grc_pkg::Y_W-1:0]};
    res.lane[grc_pkg::LN_NH3] = {y_nh3[grc_pkg::Y_W], y_nh3[grc_pkg::Y_W-1:0]};
    res.lane[grc_pkg::LN_NO2] = {y_no2[grc_pkg::Y_W], y_no2[grc_pkg::Y_W-1:0]};

    r10 = grc_pkg::CMP_W'(rc_r) * grc_pkg::CMP_W'(10);
    r100 = grc_pkg::CMP_W'(rc_r) * grc_pkg::CMP_W'(100);
    r1000 = grc_pkg::CMP_W'(rc_r) * grc_pkg::CMP_W'(1000);
    res.propane = (r100 <= grc_pkg::TH_PROPANE);
    res.isobutane = (r100 <= grc_pkg::TH_ISOBUT);
    res.h2s = ((r100 > grc_pkg::TH_H2S_LO) && (r100 < grc_pkg::TH_H2S_HI)) ||
              (r1000 < grc_pkg::TH_H2S_LOW);
    res.nitric = (r10 <= grc_pkg::TH_NO);
  end

endmodule

// ===== rtl/core/grc_cdiv.sv =====
// ----------------------------------------------------------------------------
// grc_cdiv
// One concentration lane: bit-serial divide by the curve constant, then clamp.
// ----------------------------------------------------------------------------
module grc_cdiv (
  input  logic                        clk,
  input  logic                        start,
  input  logic                        en,
  input  grc_pkg::lane_op_t           op,
  input  logic [grc_pkg::DIV_W-1:0]   divisor,
  input  logic [grc_pkg::VAL_W-1:0]   low,
  input  logic [grc_pkg::VAL_W-1:0]   high,
  output logic [grc_pkg::VAL_W-1:0]   value
);

  logic                        neg_r, neg_nxt;
  logic [grc_pkg::DIV_W-1:0]   rem_r, rem_nxt;
  logic [grc_pkg::LQ_W-1:0]    quo_r, quo_nxt;
  logic [grc_pkg::DIV_W:0]     trial;
  logic [grc_pkg::DIV_W:0]     diff;
  logic                        ge;

  always_comb begin
    trial = {rem_r, quo_r[grc_pkg::LQ_W-1]};
    diff = trial - {1'b0, divisor};
    ge = (trial >= {1'b0, divisor});
    neg_nxt = neg_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    if (start) begin
      // operand top bits are below the divisor, so the quotient fits the lane
      neg_nxt = op.neg;
      rem_nxt = grc_pkg::DIV_W'(op.mag[grc_pkg::Y_W-1:grc_pkg::LQ_W]);
      quo_nxt = op.mag[grc_pkg::LQ_W-1:0];
    end else if (en) begin
      rem_nxt = ge ? diff[grc_pkg::DIV_W-1:0] : trial[grc_pkg::DIV_W-1:0];
      quo_nxt = {quo_r[grc_pkg::LQ_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  always_comb begin
    if (neg_r) begin
      value = '0;
    end else if (quo_r > {1'b0, high}) begin
      value = high;
    end else if (quo_r < {1'b0, low}) begin
      value = '0;
    end else begin
      value = quo_r[grc_pkg::VAL_W-1:0];
    end
  end

endmodule

// ===== rtl/core/gas_ratio_to_concentration.sv =====
// ----------------------------------------------------------------------------
// gas_ratio_to_concentration
// Baseline capture, serial ratio division and six serial concentration lanes.
// ----------------------------------------------------------------------------
//  channel | direction | ports                          | item
//  in      | sink      | in_tvalid/tready/tdata/tuser   | kind + three raw readings
//  out     | source    | out_tvalid/tready/tdata/tuser  | concentrations, flags, fault
//
//  A measure item is accepted in ST_IDLE, runs through the two ratio dividers in ST_RDIV
//  (one quotient bit a cycle), is clamped in ST_CLAMP, loaded into the lanes in ST_SCALE,
//  divided in the concentration lanes in ST_CDIV and written to the output register
//  from ST_DONE once that register has room. Calibrate items and measure items before
//  any calibration give no result; a zero baseline gives a fault result. in_tready is
//  high only while no item is in flight; a result waiting in the output register does
//  not block the next item.
//  Reset clears the baselines and their valid flag.
module gas_ratio_to_concentration (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [15:0] ox_raw, [31:16] red_raw, [47:32] power_raw
  input  logic [grc_pkg::IN_DATA_W-1:0]     in_tdata,
  // [0] kind
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [9:0] co_ppm, [24:10] methane_ppm, [33:25] ethanol_ppm, [43:34] hydrogen_ppm,
  // [52:44] ammonia_ppm, [62:53] no2_centi_ppm, [72:63] detect_flags, [79:73] zero
  output logic [grc_pkg::OUT_DATA_W-1:0]    out_tdata,
  // [0] divide_fault
  output logic                              out_tuser
);

  grc_pkg::state_t state_r, state_nxt;
  logic [grc_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [grc_pkg::RAW_W-1:0]      ox_base_r, ox_base_nxt;
  logic [grc_pkg::RAW_W-1:0]      red_base_r, red_base_nxt;
  logic                           base_valid_r, base_valid_nxt;
  logic                           ox_neg_r, ox_neg_nxt;
  logic                           red_neg_r, red_neg_nxt;
  logic                           fault_r, fault_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [grc_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                           out_fault_r, out_fault_nxt;

  logic                           accept;
  logic [grc_pkg::RAW_W-1:0]      ox_raw, red_raw, power_raw;
  logic [grc_pkg::RAW_W:0]        ox_d, red_d;
  logic [grc_pkg::RAW_W-1:0]      ox_rev, red_rev;
  logic [grc_pkg::RAW_W-1:0]      ox_mag, red_mag;
  logic                           base_zero;
  logic                           rdiv_load, rdiv_en, clamp_en, lane_start, lane_en;
  logic                           out_load;
  logic [grc_pkg::RQ_W-1:0]       ox_q, red_q;
  grc_pkg::scale_t                scl;
  logic [grc_pkg::VAL_W-1:0]      lane_val [grc_pkg::NLANE];
  logic [grc_pkg::FLAGS_W-1:0]    flags;
  logic [grc_pkg::CO_W-1:0]       co_v;
  logic [grc_pkg::CH4_W-1:0]      ch4_v;
  logic [grc_pkg::ETH_W-1:0]      eth_v;
  logic [grc_pkg::H2_W-1:0]       h2_v;
  logic [grc_pkg::NH3_W-1:0]      nh3_v;
  logic [grc_pkg::NO2_W-1:0]      no2_v;

  assign in_tready = (state_r == grc_pkg::ST_IDLE);
  assign accept = in_tvalid & in_tready;

  assign ox_raw = in_tdata[15:0];
  assign red_raw = in_tdata[31:16];
  assign power_raw = in_tdata[47:32];

  always_comb begin
    ox_d = {1'b0, power_raw} - {1'b0, ox_raw};
    red_d = {1'b0, power_raw} - {1'b0, red_raw};
    ox_rev = ox_raw - power_raw;
    red_rev = red_raw - power_raw;
    ox_mag = ox_d[grc_pkg::RAW_W] ? ox_rev : ox_d[grc_pkg::RAW_W-1:0];
    red_mag = red_d[grc_pkg::RAW_W] ? red_rev : red_d[grc_pkg::RAW_W-1:0];
  end

  assign base_zero = (ox_base_r == '0) || (red_base_r == '0);

  grc_rdiv u_ox_div (
    .clk     (clk),
    .load    (rdiv_load),
    .en      (rdiv_en),
    .mag     (ox_mag),
    .divisor (ox_base_r),
    .quo     (ox_q)
  );

  grc_rdiv u_red_div (
    .clk     (clk),
    .load    (rdiv_load),
    .en      (rdiv_en),
    .mag     (red_mag),
    .divisor (red_base_r),
    .quo     (red_q)
  );

  grc_scale u_scale (
    .clk      (clk),
    .clamp_en (clamp_en),
    .red_q    (red_q),
    .red_neg  (red_neg_r),
    .ox_q     (ox_q),
    .ox_neg   (ox_neg_r),
    .res      (scl)
  );

  for (genvar i = 0; i < grc_pkg::NLANE; i++) begin : g_lane
    grc_cdiv u_lane (
      .clk     (clk),
      .start   (lane_start),
      .en      (lane_en),
      .op      (scl.lane[i]),
      .divisor (grc_pkg::LANE_DIV[i]),
      .low     (grc_pkg::LANE_LOW[i]),
      .high    (grc_pkg::LANE_HIGH[i]),
      .value   (lane_val[i])
    );
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    ox_base_nxt = ox_base_r;
    red_base_nxt = red_base_r;
    base_valid_nxt = base_valid_r;
    ox_neg_nxt = ox_neg_r;
    red_neg_nxt = red_neg_r;
    fault_nxt = fault_r;
    rdiv_load = 1'b0;
    rdiv_en = 1'b0;
    clamp_en = 1'b0;
    lane_start = 1'b0;
    lane_en = 1'b0;
    out_load = 1'b0;
    case (state_r)
      grc_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_tuser == grc_pkg::KIND_CAL) begin
            ox_base_nxt = ox_d[grc_pkg::RAW_W-1:0];
            red_base_nxt = red_d[grc_pkg::RAW_W-1:0];
            base_valid_nxt = 1'b1;
          end else if (base_valid_r) begin
            if (base_zero) begin
              fault_nxt = 1'b1;
              state_nxt = grc_pkg::ST_DONE;
            end else begin
              fault_nxt = 1'b0;
              ox_neg_nxt = ox_d[grc_pkg::RAW_W];
              red_neg_nxt = red_d[grc_pkg::RAW_W];
              rdiv_load = 1'b1;
              cnt_nxt = '0;
              state_nxt = grc_pkg::ST_RDIV;
            end
          end
        end
      end
      grc_pkg::ST_RDIV: begin
        rdiv_en = 1'b1;
        cnt_nxt = cnt_r + grc_pkg::CNT_W'(1);
        if (cnt_r == grc_pkg::CNT_W'(grc_pkg::RDIV_STEPS - 1)) begin
          state_nxt = grc_pkg::ST_CLAMP;
        end
      end
      grc_pkg::ST_CLAMP: begin
        clamp_en = 1'b1;
        state_nxt = grc_pkg::ST_SCALE;
      end
      grc_pkg::ST_SCALE: begin
        lane_start = 1'b1;
        cnt_nxt = '0;
        state_nxt = grc_pkg::ST_CDIV;
      end
      grc_pkg::ST_CDIV: begin
        lane_en = 1'b1;
        cnt_nxt = cnt_r + grc_pkg::CNT_W'(1);
        if (cnt_r == grc_pkg::CNT_W'(grc_pkg::CDIV_STEPS - 1)) begin
          state_nxt = grc_pkg::ST_DONE;
        end
      end
      grc_pkg::ST_DONE: begin
        // wait for room in the output register
        if (!out_valid_r || out_tready) begin
          out_load = 1'b1;
          state_nxt = grc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = grc_pkg::ST_IDLE;
      end
    endcase
  end

  // result assembly
  always_comb begin
    co_v = lane_val[grc_pkg::LN_CO][grc_pkg::CO_W-1:0];
    ch4_v = lane_val[grc_pkg::LN_CH4][grc_pkg::CH4_W-1:0];
    eth_v = lane_val[grc_pkg::LN_ETH][grc_pkg::ETH_W-1:0];
    h2_v = lane_val[grc_pkg::LN_H2][grc_pkg::H2_W-1:0];
    nh3_v = lane_val[grc_pkg::LN_NH3][grc_pkg::NH3_W-1:0];
    no2_v = lane_val[grc_pkg::LN_NO2][grc_pkg::NO2_W-1:0];
    flags = '0;
    flags[grc_pkg::FL_CO] = (co_v != '0);
    flags[grc_pkg::FL_CH4] = (ch4_v != '0);
    flags[grc_pkg::FL_ETH] = (eth_v != '0);
    flags[grc_pkg::FL_PROPANE] = scl.propane;
    flags[grc_pkg::FL_ISOBUT] = scl.isobutane;
    flags[grc_pkg::FL_H2] = (h2_v != '0);
    flags[grc_pkg::FL_H2S] = scl.h2s;
    flags[grc_pkg::FL_NH3] = (nh3_v != '0);
    flags[grc_pkg::FL_NO] = scl.nitric;
    flags[grc_pkg::FL_NO2] = (no2_v != '0);

    out_data_nxt = out_data_r;
    out_fault_nxt = out_fault_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_fault_nxt = fault_r;
      if (fault_r) begin
        out_data_nxt = '0;
      end else begin
        out_data_nxt = {{grc_pkg::OUT_PAD_W{1'b0}}, flags, no2_v, nh3_v, h2_v,
                        eth_v, ch4_v, co_v};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= grc_pkg::ST_IDLE;
      cnt_r <= '0;
      ox_base_r <= '0;
      red_base_r <= '0;
      base_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      ox_base_r <= ox_base_nxt;
      red_base_r <= red_base_nxt;
      base_valid_r <= base_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ox_neg_r <= ox_neg_nxt;
    red_neg_r <= red_neg_nxt;
    fault_r <= fault_nxt;
    out_data_r <= out_data_nxt;
    out_fault_r <= out_fault_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tuser = out_fault_r;

endmodule
